// ===== rtl/core/button_pwm_generator_control_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button PWM generator control
// Shared checker shorthands, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PWM_GENERATOR_CONTROL_DEFINES_SVH
`define BUTTON_PWM_GENERATOR_CONTROL_DEFINES_SVH

// Same-cycle implication.
`define BPG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpg: same-cycle check failed");

// Next-cycle implication.
`define BPG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpg: next-cycle check failed");

`endif

// ===== rtl/core/bpg_pkg.sv =====
// ----------------------------------------------------------------------------
// bpg_pkg
// Widths, constants, range tables and shared types of the PWM generator control.
// ----------------------------------------------------------------------------
`default_nettype none

package bpg_pkg;

  localparam int CLOCK_HZ  = 16000000;
  localparam int REPEAT_MS = 50;
  localparam int SLOW_DIV  = 8;

  localparam int FREQ_W = 17;
  localparam int DUTY_W = 7;
  localparam int TOP_W  = 16;
  localparam int PROD_W = TOP_W + DUTY_W;
  localparam int DVD_W  = $clog2(CLOCK_HZ + 1);
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int MCNT_W = $clog2(DUTY_W);

  localparam logic [DUTY_W-1:0] DUTY_MAX   = DUTY_W'(100);
  localparam logic [DUTY_W-1:0] DUTY_START = DUTY_W'(50);
  localparam logic [DUTY_W-1:0] DUTY_ONE   = DUTY_W'(1);
  localparam logic [31:0]       REPEAT_LIM = 32'(REPEAT_MS);

  localparam logic [DVD_W-1:0]  DVD_SLOW = DVD_W'(CLOCK_HZ / SLOW_DIV);
  localparam logic [DVD_W-1:0]  DVD_FAST = DVD_W'(CLOCK_HZ);
  localparam logic [DVD_W-1:0]  DVD_ONE  = DVD_W'(1);
  localparam logic [FREQ_W-1:0] DSR_PCT  = FREQ_W'(100);
  localparam logic [CNT_W-1:0]  DIV_STEPS = CNT_W'(DVD_W);
  localparam logic [MCNT_W-1:0] MUL_LAST  = MCNT_W'(DUTY_W - 1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_FREQ = 2'd1;
  localparam logic [1:0] MODE_DUTY = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [FREQ_W-1:0] range_min(input logic [1:0] r);
    logic [FREQ_W-1:0] v;
    case (r)
      2'd0:    v = FREQ_W'(31);
      2'd1:    v = FREQ_W'(1000);
      2'd2:    v = FREQ_W'(10000);
      2'd3:    v = FREQ_W'(40000);
      default: v = FREQ_W'(31);
    endcase
    return v;
  endfunction

  function automatic logic [FREQ_W-1:0] range_max(input logic [1:0] r);
    logic [FREQ_W-1:0] v;
    case (r)
      2'd0:    v = FREQ_W'(1000);
      2'd1:    v = FREQ_W'(10000);
      2'd2:    v = FREQ_W'(40000);
      2'd3:    v = FREQ_W'(100000);
      default: v = FREQ_W'(1000);
    endcase
    return v;
  endfunction

  function automatic logic [FREQ_W-1:0] range_step(input logic [1:0] r);
    logic [FREQ_W-1:0] v;
    case (r)
      2'd0:    v = FREQ_W'(1);
      2'd1:    v = FREQ_W'(10);
      2'd2:    v = FREQ_W'(100);
      2'd3:    v = FREQ_W'(1000);
      default: v = FREQ_W'(1);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bpg_div.sv =====
// ----------------------------------------------------------------------------
// bpg_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpg_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bpg_pkg::div_req_t req,
  output bpg_pkg::div_rsp_t      rsp
);

  logic [bpg_pkg::DVD_W-1:0]  dvd_r;
  logic [bpg_pkg::FREQ_W-1:0] rem_r;
  logic [bpg_pkg::FREQ_W-1:0] dsr_r;
  logic [bpg_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [bpg_pkg::FREQ_W:0]   rem_sh;
  logic [bpg_pkg::FREQ_W:0]   rem_sub;
  logic                       ge;

  // A zero divisor always compares as fitting, so the quotient ends all ones.
  assign rem_sh  = {rem_r, dvd_r[bpg_pkg::DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= bpg_pkg::DIV_STEPS;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[bpg_pkg::FREQ_W-1:0] : rem_sh[bpg_pkg::FREQ_W-1:0];
        dvd_r <= {dvd_r[bpg_pkg::DVD_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == bpg_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

`default_nettype wire

// ===== rtl/core/button_pwm_generator_control.sv =====
// ----------------------------------------------------------------------------
// button_pwm_generator_control
// Menu and timer control of a button-driven PWM generator.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en / cfg_wr_data write the frequency range (0 to 3), taken by the
//   next start item. Input items arrive on in_*: in_tuser low starts the
//   generator, high is a button poll tick with flags and a millisecond time.
//   Every input item yields exactly one status item on out_*.
//   Throughput is one item at a time. An item that reprograms the timer runs
//   a 24-step bit-serial division of the clock (divided by 8 in range 0) by
//   the frequency, a 7-step shift-add multiply by the duty and a second
//   24-step division by 100, which share one serial divider. A duty change
//   skips the first division; a tick that touches neither goes straight to
//   the result. The next item is accepted in the cycle after the result is loaded.
//   The result sits in an output register; the next item is accepted while it
//   waits, and a finished result stalls in the last step until out_tready.
//   Reset clears the control and menu state: generator stopped, range 0, values zero, and
//   in_tready stays low while rst_n is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_pwm_generator_control_defines.svh"

module button_pwm_generator_control (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,   // range_index
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // up_press, down_press, up_long, down_long, enter_press, back_press,
  // now_ms[31:0], zero pad
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tuser,      // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // output_enable, prescale_div8, period_top[15:0], compare_level[15:0],
  // counter_reload, frequency_hz[16:0], duty_percent[6:0], cursor_row,
  // adjust_mode[1:0], running, zero pad
  output logic [63:0]      out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_TOP_GO, S_TOP_WAIT, S_MUL, S_CMP_GO, S_CMP_WAIT, S_DONE
  } state_t;

  state_t                      state_r;
  logic [1:0]                  range_index_r;
  logic                        active_r;
  logic [1:0]                  latched_r;
  logic                        adj_freq_r;
  logic                        adj_duty_r;
  logic                        cursor_r;
  logic [bpg_pkg::FREQ_W-1:0]  freq_r;
  logic [bpg_pkg::DUTY_W-1:0]  duty_r;
  logic [31:0]                 last_rep_r;
  logic [bpg_pkg::TOP_W-1:0]   top_r;
  logic [bpg_pkg::TOP_W-1:0]   cmp_r;
  logic                        reload_r;
  logic                        back_r;
  logic [bpg_pkg::PROD_W-1:0]  acc_r;
  logic [bpg_pkg::DUTY_W-1:0]  mplier_r;
  logic [bpg_pkg::MCNT_W-1:0]  mcnt_r;
  logic                        out_valid_r;
  logic [63:0]                 out_data_r;

  logic                        active_nxt;
  logic [1:0]                  latched_nxt;
  logic                        adj_freq_nxt;
  logic                        adj_duty_nxt;
  logic                        cursor_nxt;
  logic [bpg_pkg::FREQ_W-1:0]  freq_nxt;
  logic [bpg_pkg::DUTY_W-1:0]  duty_nxt;
  logic [31:0]                 last_rep_nxt;
  logic                        back_nxt;
  logic                        do_top;
  logic                        do_cmp;

  logic                        in_fire;
  logic                        up, down, up_l, down_l, enter, back;
  logic [31:0]                 now;
  logic [31:0]                 since;
  logic                        due;
  logic [1:0]                  rng;
  logic [bpg_pkg::FREQ_W-1:0]  f_min, f_max, f_step;

  bpg_pkg::div_req_t           div_req;
  bpg_pkg::div_rsp_t           div_rsp;
  logic [bpg_pkg::DVD_W-1:0]   quot_m1;
  logic [bpg_pkg::TOP_W-1:0]   top_new;
  logic [bpg_pkg::TOP_W-1:0]   top_fin;
  logic [bpg_pkg::PROD_W-1:0]  acc_add;
  logic [1:0]                  mode_code;
  logic [63:0]                 out_pack;
  logic                        out_free;

  assign up     = in_tdata[0];
  assign down   = in_tdata[1];
  assign up_l   = in_tdata[2];
  assign down_l = in_tdata[3];
  assign enter  = in_tdata[4];
  assign back   = in_tdata[5];
  assign now    = in_tdata[37:6];

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign since  = now - last_rep_r;
  assign due    = since >= bpg_pkg::REPEAT_LIM;
  assign rng    = latched_r;
  assign f_min  = bpg_pkg::range_min(rng);
  assign f_max  = bpg_pkg::range_max(rng);
  assign f_step = bpg_pkg::range_step(rng);

  // Menu update for one item. After one hold repeat fires in a tick, the
  // fired flag keeps the other direction from repeating in that tick.
  always_comb begin
    logic fired;
    fired        = 1'b0;
    active_nxt   = active_r;
    latched_nxt  = latched_r;
    adj_freq_nxt = adj_freq_r;
    adj_duty_nxt = adj_duty_r;
    cursor_nxt   = cursor_r;
    freq_nxt     = freq_r;
    duty_nxt     = duty_r;
    last_rep_nxt = last_rep_r;
    back_nxt     = 1'b0;
    do_top       = 1'b0;
    do_cmp       = 1'b0;
    if (in_tuser == bpg_pkg::OP_START) begin
      active_nxt   = 1'b1;
      latched_nxt  = range_index_r;
      adj_freq_nxt = 1'b0;
      adj_duty_nxt = 1'b0;
      cursor_nxt   = 1'b0;
      freq_nxt     = bpg_pkg::range_min(range_index_r);
      duty_nxt     = bpg_pkg::DUTY_START;
      do_top       = 1'b1;
      do_cmp       = 1'b1;
    end else if (active_r) begin
      if (!adj_freq_r && !adj_duty_r) begin
        if (up) begin
          cursor_nxt = 1'b0;
        end
        if (down) begin
          cursor_nxt = 1'b1;
        end
      end
      if (enter) begin
        if (!cursor_nxt) begin
          adj_duty_nxt = 1'b0;
          adj_freq_nxt = !adj_freq_r;
        end else begin
          adj_freq_nxt = 1'b0;
          adj_duty_nxt = !adj_duty_r;
        end
      end
      if (adj_freq_nxt) begin
        if (freq_nxt < f_max) begin
          if (up) begin
            freq_nxt = freq_nxt + f_step;
          end
          if (up_l && due) begin
            freq_nxt     = freq_nxt + f_step;
            last_rep_nxt = now;
            fired        = 1'b1;
          end
        end
        if (freq_nxt > f_min) begin
          if (down) begin
            freq_nxt = freq_nxt - f_step;
          end
          if (down_l && due && !fired) begin
            freq_nxt     = freq_nxt - f_step;
            last_rep_nxt = now;
          end
        end
        do_top = 1'b1;
        do_cmp = 1'b1;
      end
      if (adj_duty_nxt) begin
        if (up && duty_nxt < bpg_pkg::DUTY_MAX) begin
          duty_nxt = duty_nxt + bpg_pkg::DUTY_ONE;
        end
        if (down && duty_nxt != '0) begin
          duty_nxt = duty_nxt - bpg_pkg::DUTY_ONE;
        end
        if (up_l && due) begin
          if (duty_nxt < bpg_pkg::DUTY_MAX) begin
            duty_nxt = duty_nxt + bpg_pkg::DUTY_ONE;
          end
          last_rep_nxt = now;
          fired        = 1'b1;
        end
        if (down_l && due && !fired) begin
          if (duty_nxt != '0) begin
            duty_nxt = duty_nxt - bpg_pkg::DUTY_ONE;
          end
          last_rep_nxt = now;
        end
        do_cmp = 1'b1;
      end
      if (back) begin
        active_nxt   = 1'b0;
        adj_freq_nxt = 1'b0;
        adj_duty_nxt = 1'b0;
        cursor_nxt   = 1'b0;
        back_nxt     = 1'b1;
      end
    end
  end

  always_comb begin
    div_req.start    = (state_r == S_TOP_GO) || (state_r == S_CMP_GO);
    div_req.dividend = {{(bpg_pkg::DVD_W - bpg_pkg::PROD_W){1'b0}}, acc_r};
    div_req.divisor  = bpg_pkg::DSR_PCT;
    if (state_r == S_TOP_GO) begin
      div_req.dividend = (latched_r == 2'd0) ? bpg_pkg::DVD_SLOW : bpg_pkg::DVD_FAST;
      div_req.divisor  = freq_r;
    end
  end

  bpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign quot_m1 = div_rsp.quotient - bpg_pkg::DVD_ONE;
  assign top_new = quot_m1[bpg_pkg::TOP_W-1:0];
  assign acc_add = mplier_r[bpg_pkg::DUTY_W-1] ?
                   {{(bpg_pkg::PROD_W - bpg_pkg::TOP_W){1'b0}}, top_r} : '0;

  // Back clears the period at the result step, after any compare update from it.
  assign top_fin   = back_r ? '0 : top_r;
  assign mode_code = adj_freq_r ? bpg_pkg::MODE_FREQ :
                     (adj_duty_r ? bpg_pkg::MODE_DUTY : bpg_pkg::MODE_NONE);
  assign out_pack  = {1'b0, active_r, mode_code, cursor_r, duty_r, freq_r,
                      reload_r && !back_r, cmp_r, top_fin,
                      active_r && (latched_r == 2'd0), active_r};
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      range_index_r <= 2'd0;
      active_r      <= 1'b0;
      latched_r     <= 2'd0;
      adj_freq_r    <= 1'b0;
      adj_duty_r    <= 1'b0;
      cursor_r      <= 1'b0;
      freq_r        <= '0;
      duty_r        <= '0;
      last_rep_r    <= '0;
      top_r         <= '0;
      cmp_r         <= '0;
      reload_r      <= 1'b0;
      back_r        <= 1'b0;
      mcnt_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        range_index_r <= cfg_wr_data;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            active_r   <= active_nxt;
            latched_r  <= latched_nxt;
            adj_freq_r <= adj_freq_nxt;
            adj_duty_r <= adj_duty_nxt;
            cursor_r   <= cursor_nxt;
            freq_r     <= freq_nxt;
            duty_r     <= duty_nxt;
            last_rep_r <= last_rep_nxt;
            back_r     <= back_nxt;
            reload_r   <= 1'b0;
            acc_r      <= '0;
            mplier_r   <= duty_nxt;
            mcnt_r     <= bpg_pkg::MUL_LAST;
            if (do_top) begin
              state_r <= S_TOP_GO;
            end else if (do_cmp) begin
              state_r <= S_MUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_TOP_GO: begin
          state_r <= S_TOP_WAIT;
        end
        S_TOP_WAIT: begin
          if (div_rsp.done) begin
            reload_r <= (top_new != top_r);
            top_r    <= top_new;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r    <= {acc_r[bpg_pkg::PROD_W-2:0], 1'b0} + acc_add;
          mplier_r <= {mplier_r[bpg_pkg::DUTY_W-2:0], 1'b0};
          mcnt_r   <= mcnt_r - 1'b1;
          if (mcnt_r == '0) begin
            state_r <= S_CMP_GO;
          end
        end
        S_CMP_GO: begin
          state_r <= S_CMP_WAIT;
        end
        S_CMP_WAIT: begin
          if (div_rsp.done) begin
            cmp_r   <= div_rsp.quotient[bpg_pkg::TOP_W-1:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r  <= out_pack;
            top_r       <= top_fin;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `BPG_ASSERT_IMP(a_modes_excl, 1'b1, !(adj_freq_r && adj_duty_r))
  `BPG_ASSERT_IMP(a_div_done_wait, div_rsp.done, (state_r == S_TOP_WAIT) || (state_r == S_CMP_WAIT))
  `BPG_ASSERT_IMP(a_stopped_top, out_valid_r && !out_data_r[0], out_data_r[17:2] == '0)
  `BPG_ASSERT_NXT(a_done_loads, (state_r == S_DONE) && out_free, out_valid_r && (state_r == S_IDLE))

endmodule

`default_nettype wire
